// File: design/cbm5_pkg.sv
// cbm5_pkg: shared types, codes and constants of the bank controller
// used by cbm5_ctrl, cbm5_mod, cbm5_dp and cartridge_bank_mapper_mbc5
package cbm5_pkg;

  // access kinds carried on the input tuser
  localparam logic [1:0] FUNC_ROM_RD = 2'd0;
  localparam logic [1:0] FUNC_REG_WR = 2'd1;
  localparam logic [1:0] FUNC_RAM_RD = 2'd2;
  localparam logic [1:0] FUNC_RAM_WR = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_TOTAL = 2'd0;
  localparam logic [1:0] CFG_RAM_TOTAL = 2'd1;
  localparam logic [1:0] CFG_RUMBLE    = 2'd2;

  // field widths
  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int ROM_ADDR_W  = 23;
  localparam int ROM_TOTAL_W = 10;
  localparam int RAM_TOTAL_W = 5;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int ROM_SEL_W   = 9;
  localparam int RAM_SEL_W   = 4;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 40;

  // bank geometry
  localparam int ROM_BANKS_MAX     = 512;
  localparam int RAM_BANKS_MAX_DEF = 16;
  localparam int RAM_BANK_BYTES    = 8192;
  localparam int RAM_OFF_W         = 13;
  localparam int RAM_ADDR_FULL_W   = RAM_SEL_W + RAM_OFF_W;

  // address map
  localparam logic [15:0] ROM_BANK0_HI = 16'h3FFF;
  localparam logic [15:0] REG_EN_HI    = 16'h1FFF;
  localparam logic [15:0] REG_LO8_HI   = 16'h2FFF;
  localparam logic [15:0] REG_RAMB_HI  = 16'h5FFF;
  localparam logic [15:0] RAM_WIN_LO   = 16'hA000;
  localparam logic [15:0] RAM_WIN_HI   = 16'hBFFF;
  localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
  localparam logic [7:0]  READ_IDLE    = 8'hFF;

  // remainder unit: 9 dividend bits, 3 per cycle
  localparam int DVD_W      = ROM_SEL_W;
  localparam int DVS_W      = ROM_TOTAL_W;
  localparam int STEP_BITS  = 3;
  localparam int DIV_STEPS  = DVD_W / STEP_BITS;
  localparam int DIV_CNT_W  = 2;

  // controller to datapath
  typedef struct packed {
    logic load;      // input beat accepted, start remainder
    logic apply;     // update state, access battery ram
    logic out_load;  // capture result into output register
  } cbm5_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;  // remainder ready after this edge
  } cbm5_stat_t;

endpackage

// File: design/cartridge_bank_mapper_mbc5.sv
// cartridge_bank_mapper_mbc5: top level of the cartridge bank controller
// depends on cbm5_pkg, cbm5_ctrl, cbm5_dp (which holds cbm5_mod)
//
//   channel  signals                      beat
//   s        s_tvalid s_tready            one bus access
//            s_tdata s_tuser
//   m        m_tvalid m_tready m_tdata    one access result
//   cfg      cfg_we cfg_index cfg_data    one register write
//
// an access passes from accept to output valid through the remainder unit (three
// quotient bits a cycle for the bank modulo), a step to update state and read or
// write battery ram, and a step to load the output register
// a new beat can be taken in the cycle after the previous result is loaded into
// the output register, so one access is finished before the next is accepted
// reset is synchronous; battery ram is not cleared and needs no clearing pass
// a stalled output holds the next result in the done step until taken
module cartridge_bank_mapper_mbc5 import cbm5_pkg::*; #(
  parameter int RAM_BANKS_MAX = RAM_BANKS_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // bus_address[15:0], write_byte[23:16]
  input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // rom_byte_address[22:0], read_data[30:23],
                                           // bank_changed[31], rumble_on[32], zero[39:33]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cbm5_cmd_t  cmd;
  cbm5_stat_t stat;

  cbm5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  cbm5_dp #(
    .RAM_BANKS_MAX (RAM_BANKS_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: design/cbm5_ctrl.sv
// cbm5_ctrl: sequencing of one bus access per input beat
// depends on cbm5_pkg (command and status structs)
module cbm5_ctrl import cbm5_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  output cbm5_cmd_t  cmd,
  input  cbm5_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  // commands decoded from state
  always_comb begin
    out_free     = !m_tvalid || m_tready;
    s_tready     = (state == ST_IDLE);
    cmd.load     = (state == ST_IDLE) && s_tvalid;
    cmd.apply    = (state == ST_APPLY);
    cmd.out_load = (state == ST_DONE) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // valid rises when a result is loaded, falls when it is taken
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_DIV;
        end
        ST_DIV: begin
          if (stat.div_done) state <= ST_APPLY;
        end
        ST_APPLY: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // remainder finishes only while waiting for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> state == ST_DIV)
    else $error("remainder done outside divide state");

  // result never overwrites a beat not yet taken
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // an accepted beat goes straight into the remainder unit
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == ST_DIV)
    else $error("accept did not start divide");

  // state update is followed by result capture
  a_apply_done: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> state == ST_DONE)
    else $error("apply not followed by done");
`endif

endmodule

// File: design/cbm5_mod.sv
// cbm5_mod: iterative remainder, restoring, three quotient bits per cycle
// depends on cbm5_pkg (widths and step count)
module cbm5_mod import cbm5_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     dvd;
  logic [DVS_W-1:0]     dvs;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     rem_next;
  logic [DVD_W-1:0]     dvd_next;

  // three restoring steps per cycle
  always_comb begin
    logic [DVS_W:0] t;
    rem_next = rem;
    dvd_next = dvd;
    t        = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t        = {rem_next, dvd_next[DVD_W-1]};
      dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) t = t - {1'b0, dvs};
      rem_next = t[DVS_W-1:0];
    end
  end

  assign done      = busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign remainder = rem[DVD_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) busy <= 1'b0;
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

endmodule

// File: design/cbm5_dp.sv
// cbm5_dp: configuration, bank registers, battery ram and result register
// depends on cbm5_pkg and cbm5_mod
module cbm5_dp import cbm5_pkg::*; #(
  parameter int RAM_BANKS_MAX = RAM_BANKS_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [FUNC_W-1:0]     s_tuser,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  cbm5_cmd_t             cmd,
  output cbm5_stat_t            stat
);

  localparam int RAM_DEPTH = RAM_BANKS_MAX * RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // configuration
  logic [ROM_TOTAL_W-1:0] rom_total;
  logic [RAM_TOTAL_W-1:0] ram_total;
  logic                   rumble_fitted;

  // cartridge state
  logic [ROM_SEL_W-1:0] rom_sel;
  logic [RAM_SEL_W-1:0] ram_sel;
  logic                 ram_en;
  logic                 rumble;

  // latched access
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] wbyte;

  // per access results
  logic [ROM_ADDR_W-1:0] rom_addr;
  logic                  changed;
  logic                  rd_ok;
  logic [BYTE_W-1:0]     mem_q;
  logic [BYTE_W-1:0]     mem [RAM_DEPTH];

  logic [ROM_TOTAL_W-1:0]     rom_cnt;
  logic [RAM_TOTAL_W-1:0]     ram_cnt;
  logic [FUNC_W-1:0]          in_func;
  logic [ADDR_W-1:0]          in_addr;
  logic [BYTE_W-1:0]          in_byte;
  logic [DVD_W-1:0]           dividend;
  logic [DVS_W-1:0]           divisor;
  logic [DVD_W-1:0]           mod_q;
  logic                       ram_ok;
  logic [RAM_ADDR_FULL_W-1:0] ram_addr_full;
  logic [RAM_AW-1:0]          ram_addr;
  logic [BYTE_W-1:0]          read_data;

  // effective bank counts
  always_comb begin
    if (rom_total > ROM_TOTAL_W'(ROM_BANKS_MAX)) rom_cnt = ROM_TOTAL_W'(ROM_BANKS_MAX);
    else if (rom_total == '0) rom_cnt = ROM_TOTAL_W'(1);
    else rom_cnt = rom_total;
    if (ram_total > RAM_TOTAL_W'(RAM_BANKS_MAX)) ram_cnt = RAM_TOTAL_W'(RAM_BANKS_MAX);
    else ram_cnt = ram_total;
  end

  // remainder operands from the incoming beat
  always_comb begin
    in_func  = s_tuser;
    in_addr  = s_tdata[ADDR_W-1:0];
    in_byte  = s_tdata[ADDR_W +: BYTE_W];
    dividend = rom_sel;
    divisor  = rom_cnt;
    case (in_func)
      FUNC_ROM_RD: begin
        dividend = rom_sel;
        divisor  = rom_cnt;
      end
      FUNC_REG_WR: begin
        if (in_addr <= REG_LO8_HI) begin
          dividend = {rom_sel[ROM_SEL_W-1], in_byte};
          divisor  = rom_cnt;
        end else if (in_addr <= ROM_BANK0_HI) begin
          dividend = {in_byte[0], rom_sel[ROM_SEL_W-2:0]};
          divisor  = rom_cnt;
        end else begin
          dividend = rumble_fitted ? DVD_W'(in_byte[2:0]) : DVD_W'(in_byte[3:0]);
          divisor  = DVS_W'(ram_cnt);
        end
      end
      default: begin
        dividend = DVD_W'(ram_sel);
        divisor  = DVS_W'(ram_cnt);
      end
    endcase
  end

  cbm5_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (stat.div_done),
    .remainder (mod_q)
  );

  // battery ram addressing
  always_comb begin
    ram_ok        = ram_en && (addr >= RAM_WIN_LO) && (addr <= RAM_WIN_HI) &&
                    (ram_cnt != '0);
    ram_addr_full = {mod_q[RAM_SEL_W-1:0], addr[RAM_OFF_W-1:0]};
    ram_addr      = ram_addr_full[RAM_AW-1:0];
    read_data     = (func == FUNC_RAM_RD && rd_ok) ? mem_q : READ_IDLE;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_total     <= ROM_TOTAL_W'(2);
      ram_total     <= '0;
      rumble_fitted <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_TOTAL: rom_total     <= cfg_data[ROM_TOTAL_W-1:0];
        CFG_RAM_TOTAL: ram_total     <= cfg_data[RAM_TOTAL_W-1:0];
        CFG_RUMBLE:    rumble_fitted <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // register writes to the cartridge state
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_sel <= ROM_SEL_W'(1);
      ram_sel <= '0;
      ram_en  <= 1'b0;
      rumble  <= 1'b0;
    end else if (cmd.apply && func == FUNC_REG_WR) begin
      if (addr <= REG_EN_HI) begin
        ram_en <= (wbyte[3:0] == RAM_EN_KEY);
      end else if (addr <= ROM_BANK0_HI) begin
        rom_sel <= mod_q;
      end else if (addr <= REG_RAMB_HI) begin
        if (rumble_fitted) rumble <= wbyte[3];
        ram_sel <= (ram_cnt == '0) ? '0 : mod_q[RAM_SEL_W-1:0];
      end
    end
  end

  // accepted beat and per access results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func  <= in_func;
      addr  <= in_addr;
      wbyte <= in_byte;
    end
    if (cmd.apply) begin
      rd_ok   <= ram_ok;
      changed <= (func == FUNC_REG_WR) && (addr > REG_EN_HI) &&
                 (addr <= ROM_BANK0_HI) && (mod_q != rom_sel);
      if (func != FUNC_ROM_RD) rom_addr <= '0;
      else if (addr <= ROM_BANK0_HI) rom_addr <= ROM_ADDR_W'(addr);
      else rom_addr <= {mod_q, addr[13:0]};
    end
  end

  // battery ram, registered read
  always_ff @(posedge clk) begin
    if (cmd.apply && ram_ok && func == FUNC_RAM_WR) mem[ram_addr] <= wbyte;
    if (cmd.apply) mem_q <= mem[ram_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {7'b0, rumble, changed, read_data, rom_addr};
    end
  end

`ifndef SYNTHESIS
  // selected rom bank stays below the effective count after a bank write
  a_rom_sel_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && func == FUNC_REG_WR && addr > REG_EN_HI && addr <= ROM_BANK0_HI)
    |=> ({1'b0, rom_sel} < $past(rom_cnt)))
    else $error("rom bank not reduced");

  // ram bank reduced below the effective count
  a_ram_sel_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && func == FUNC_REG_WR && addr > ROM_BANK0_HI && addr <= REG_RAMB_HI &&
     ram_cnt != '0) |=> (RAM_TOTAL_W'(ram_sel) < $past(ram_cnt)))
    else $error("ram bank not reduced");

  // rumble bit never moves on a cart without a motor
  a_rumble_fixed: assert property (@(posedge clk) disable iff (rst)
    !rumble_fitted && !$past(rumble_fitted) |-> $stable(rumble))
    else $error("rumble changed without motor");
`endif

endmodule
